@@ rtl/gfsk_pkg.sv @@
package gfsk_pkg;

    // Modulation constants
    localparam int SAMPLES_PER_SYMBOL = 4;
    localparam int NUM_TAPS           = 16;
    localparam int FLUSH_LEN          = 15;
    localparam int PHASE_W            = 10;
    localparam int TAP_W              = 8;
    localparam int CFG_W              = 64;
    localparam int CFG_IDX_W          = 1;

    // Sequencer counter covers both the symbol and the flush run
    localparam int SPS_W   = $clog2(SAMPLES_PER_SYMBOL);
    localparam int FLUSH_W = $clog2(FLUSH_LEN);
    localparam int CNT_W   = (SPS_W > FLUSH_W) ? SPS_W : FLUSH_W;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TAPS_LOW  = 1'b0,
        CFG_TAPS_HIGH = 1'b1
    } t_cfg_idx;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FIRST,
        ST_SYMBOL,
        ST_FLUSH
    } t_ctrl_state;

    // Input request payload
    typedef struct packed {
        logic bit_value;
        logic first_bit;
        logic last_bit;
    } t_in_item;

    // Output request payload
    typedef struct packed {
        logic signed [7:0] i_sample;
        logic signed [7:0] q_sample;
        logic              last_sample;
    } t_out_item;

    // Sequencer to datapath: one sample step
    typedef struct packed {
        logic issue;    // push one sample this cycle
        logic clear;    // clear line and phase, emit phase-zero pair
        logic imp_nz;   // impulse is nonzero
        logic imp_neg;  // nonzero impulse is -1
        logic last;     // final sample of the item
    } t_dp_cmd;

    // Datapath to sequencer
    typedef struct packed {
        logic adv;      // pipeline advances this cycle
    } t_dp_stat;

    // round(127*sin(pi/2 * r/256)), r = 0..256
    localparam logic [6:0] QSIN_TBL [0:256] = '{
          0,   1,   2,   2,   3,   4,   5,   5,   6,   7,
          8,   9,   9,  10,  11,  12,  12,  13,  14,  15,
         16,  16,  17,  18,  19,  19,  20,  21,  22,  22,
         23,  24,  25,  26,  26,  27,  28,  29,  29,  30,
         31,  32,  32,  33,  34,  35,  35,  36,  37,  38,
         38,  39,  40,  41,  41,  42,  43,  44,  44,  45,
         46,  46,  47,  48,  49,  49,  50,  51,  51,  52,
         53,  54,  54,  55,  56,  56,  57,  58,  58,  59,
         60,  61,  61,  62,  63,  63,  64,  65,  65,  66,
         67,  67,  68,  69,  69,  70,  71,  71,  72,  72,
         73,  74,  74,  75,  76,  76,  77,  78,  78,  79,
         79,  80,  81,  81,  82,  82,  83,  84,  84,  85,
         85,  86,  86,  87,  88,  88,  89,  89,  90,  90,
         91,  91,  92,  93,  93,  94,  94,  95,  95,  96,
         96,  97,  97,  98,  98,  99,  99, 100, 100, 101,
        101, 102, 102, 102, 103, 103, 104, 104, 105, 105,
        106, 106, 106, 107, 107, 108, 108, 109, 109, 109,
        110, 110, 111, 111, 111, 112, 112, 112, 113, 113,
        113, 114, 114, 114, 115, 115, 115, 116, 116, 116,
        117, 117, 117, 118, 118, 118, 118, 119, 119, 119,
        120, 120, 120, 120, 121, 121, 121, 121, 122, 122,
        122, 122, 122, 123, 123, 123, 123, 123, 124, 124,
        124, 124, 124, 124, 125, 125, 125, 125, 125, 125,
        125, 126, 126, 126, 126, 126, 126, 126, 126, 126,
        126, 126, 127, 127, 127, 127, 127, 127, 127, 127,
        127, 127, 127, 127, 127, 127, 127
    };

    // Full-wave sine by quarter-wave symmetry
    function automatic logic signed [7:0] gfsk_sin(input logic [PHASE_W-1:0] p);
        logic [1:0] quad;
        logic [8:0] idx;
        logic [7:0] mag;
        quad = p[PHASE_W-1:PHASE_W-2];
        idx  = quad[0] ? (9'd256 - {1'b0, p[7:0]}) : {1'b0, p[7:0]};
        mag  = {1'b0, QSIN_TBL[idx]};
        return quad[1] ? $signed(~mag + 8'd1) : $signed(mag);
    endfunction

endpackage

@@ rtl/gfsk_ctrl.sv @@
module gfsk_ctrl
    import gfsk_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_in_item i_data,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_ctrl_state      r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    t_in_item         r_item, n_item;

    logic w_sym_end;
    logic w_flush_end;
    logic w_done;
    logic w_accept;

    // End of the symbol run and of the flush run
    assign w_sym_end   = (r_cnt == CNT_W'(SAMPLES_PER_SYMBOL - 1));
    assign w_flush_end = (r_cnt == CNT_W'(FLUSH_LEN - 1));
    assign w_done      = i_stat.adv &&
                         (((r_state == ST_SYMBOL) && w_sym_end && !r_item.last_bit) ||
                          ((r_state == ST_FLUSH) && w_flush_end));
    assign w_accept    = i_valid && !o_stall;

    // Next state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_item  = r_item;
        case (r_state)
            ST_IDLE: begin
                n_state = ST_IDLE;
            end
            ST_FIRST: begin
                if (i_stat.adv) begin
                    n_state = ST_SYMBOL;
                end
            end
            ST_SYMBOL: begin
                if (i_stat.adv) begin
                    if (w_sym_end) begin
                        n_cnt   = '0;
                        n_state = r_item.last_bit ? ST_FLUSH : ST_IDLE;
                    end else begin
                        n_cnt = CNT_W'(r_cnt + 1'b1);
                    end
                end
            end
            ST_FLUSH: begin
                if (i_stat.adv) begin
                    if (w_flush_end) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_cnt = CNT_W'(r_cnt + 1'b1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        // new request: taken when idle or on the final step of the previous one
        if (w_accept) begin
            n_item  = i_data;
            n_cnt   = '0;
            n_state = i_data.first_bit ? ST_FIRST : ST_SYMBOL;
        end
    end

    // Outputs
    always_comb begin
        o_cmd   = '0;
        o_stall = !((r_state == ST_IDLE) || w_done);
        case (r_state)
            ST_IDLE: begin
                o_cmd = '0;
            end
            ST_FIRST: begin
                o_cmd.issue = i_stat.adv;
                o_cmd.clear = 1'b1;
            end
            ST_SYMBOL: begin
                o_cmd.issue   = i_stat.adv;
                o_cmd.imp_nz  = (r_cnt == '0);
                o_cmd.imp_neg = !r_item.bit_value;
                o_cmd.last    = w_sym_end && !r_item.last_bit;
            end
            ST_FLUSH: begin
                o_cmd.issue = i_stat.adv;
                o_cmd.last  = w_flush_end;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Held request fields
    always_ff @(posedge i_clk) begin
        r_item <= n_item;
    end

endmodule

@@ rtl/gfsk_dp.sv @@
module gfsk_dp
    import gfsk_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    output t_dp_stat             o_stat,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output logic                 o_valid,
    input  logic                 i_stall,
    output t_out_item            o_data
);

    // Tap words
    logic [CFG_W-1:0] r_taps_lo;
    logic [CFG_W-1:0] r_taps_hi;

    // Impulse line: nonzero flag and sign per position
    logic [NUM_TAPS-1:0] r_imp_nz;
    logic [NUM_TAPS-1:0] r_imp_neg;
    logic [NUM_TAPS-1:0] n_imp_nz;
    logic [NUM_TAPS-1:0] n_imp_neg;

    // Filter stage
    logic               r_a_valid;
    logic               r_a_clear;
    logic               r_a_last;
    logic [PHASE_W-1:0] r_a_sum;

    // Phase stage
    logic               r_b_valid;
    logic               r_b_last;
    logic [PHASE_W-1:0] r_phase;

    // Output register
    logic      r_out_valid;
    t_out_item r_out;

    logic               w_adv;
    logic [TAP_W-1:0]   w_tap  [NUM_TAPS];
    logic [PHASE_W-1:0] w_term [NUM_TAPS];
    logic [PHASE_W-1:0] w_l1   [8];
    logic [PHASE_W-1:0] w_l2   [4];
    logic [PHASE_W-1:0] w_l3   [2];
    logic [PHASE_W-1:0] w_sum;

    // Whole pipeline moves when the output register is free or being taken
    assign w_adv      = !r_out_valid || !i_stall;
    assign o_stat.adv = w_adv;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taps_lo <= '0;
            r_taps_hi <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_TAPS_LOW:  r_taps_lo <= i_cfg_data;
                CFG_TAPS_HIGH: r_taps_hi <= i_cfg_data;
                default: begin
                    r_taps_lo <= r_taps_lo;
                end
            endcase
        end
    end

    // Line after this step's shift
    always_comb begin
        if (i_cmd.clear) begin
            n_imp_nz  = '0;
            n_imp_neg = '0;
        end else begin
            n_imp_nz  = {r_imp_nz[NUM_TAPS-2:0], i_cmd.imp_nz};
            n_imp_neg = {r_imp_neg[NUM_TAPS-2:0], i_cmd.imp_neg};
        end
    end

    // Per-tap terms, modulo the phase range
    always_comb begin
        for (int k = 0; k < NUM_TAPS; k++) begin
            logic [PHASE_W-1:0] ext;
            w_tap[k] = (k < NUM_TAPS / 2) ? r_taps_lo[(k % 8) * TAP_W +: TAP_W]
                                          : r_taps_hi[(k % 8) * TAP_W +: TAP_W];
            ext = {{(PHASE_W - TAP_W){w_tap[k][TAP_W-1]}}, w_tap[k]};
            if (!n_imp_nz[k]) begin
                w_term[k] = '0;
            end else if (n_imp_neg[k]) begin
                w_term[k] = ~ext + 1'b1;
            end else begin
                w_term[k] = ext;
            end
        end
    end

    // Adder tree
    always_comb begin
        for (int k = 0; k < 8; k++) begin
            w_l1[k] = w_term[2*k] + w_term[2*k+1];
        end
        for (int k = 0; k < 4; k++) begin
            w_l2[k] = w_l1[2*k] + w_l1[2*k+1];
        end
        for (int k = 0; k < 2; k++) begin
            w_l3[k] = w_l2[2*k] + w_l2[2*k+1];
        end
        w_sum = w_l3[0] + w_l3[1];
    end

    // Impulse line and filter stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_imp_nz  <= '0;
            r_imp_neg <= '0;
            r_a_valid <= 1'b0;
        end else if (w_adv) begin
            r_a_valid <= i_cmd.issue;
            if (i_cmd.issue) begin
                r_imp_nz  <= n_imp_nz;
                r_imp_neg <= n_imp_neg;
            end
        end
    end

    // Filter stage payload
    always_ff @(posedge i_clk) begin
        if (w_adv && i_cmd.issue) begin
            r_a_sum   <= w_sum;
            r_a_clear <= i_cmd.clear;
            r_a_last  <= i_cmd.last;
        end
    end

    // Phase accumulator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_phase   <= '0;
        end else if (w_adv) begin
            r_b_valid <= r_a_valid;
            if (r_a_valid) begin
                r_phase <= r_a_clear ? '0 : PHASE_W'(r_phase + r_a_sum);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_a_valid) begin
            r_b_last <= r_a_last;
        end
    end

    // I/Q lookup into the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_b_valid) begin
            r_out.i_sample    <= gfsk_sin(PHASE_W'(r_phase + 10'd256));
            r_out.q_sample    <= gfsk_sin(r_phase);
            r_out.last_sample <= r_b_last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

@@ rtl/gfsk_iq_modulator_unit.sv @@
// GFSK I/Q modulator: one data bit in, SAMPLES_PER_SYMBOL I/Q pairs out, one
// more with first_bit and 15 more with last_bit. Pairs pass the filter stage,
// phase stage and output register. Throughput: one pair per cycle while not
// stalled, set by the single-issue step sequencer.
// Reset (i_rst_n low, synchronous): taps, impulse line and phase cleared.
module gfsk_iq_modulator_unit
    import gfsk_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input requests
    input  logic                 i_valid,
    output logic                 o_stall,
    input  t_in_item             i_data,
    // output requests
    output logic                 o_valid,
    input  logic                 i_stall,
    output t_out_item            o_data,
    // configuration
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // Step sequencer
    gfsk_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    // Filter, phase accumulator and I/Q lookup
    gfsk_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (o_data)
    );

endmodule
